// ----- rtl/ocpd_pkg.sv -----
package ocpd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int TIME_W        = 16;
    localparam int COUNT_W       = 4;
    localparam int SAMPLE_FIELDS = 8;
    localparam int BATCH_SIZE    = 8;
    localparam int USABLE_MAX    = (BATCH_SIZE < SAMPLE_FIELDS) ? BATCH_SIZE : SAMPLE_FIELDS;
    localparam int SAMPLE_IDX_W  = $clog2(SAMPLE_FIELDS);
    localparam int SUM_W         = SAMPLE_W + $clog2(SAMPLE_FIELDS);
    localparam int PROD_W        = SAMPLE_W + COUNT_W;
    localparam int QUEUE_DEPTH   = 2;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW    = 2'd1;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd10000;
    localparam logic [TIME_W-1:0]   WINDOW_RESET    = 16'd50;

    typedef struct packed {
        logic [COUNT_W-1:0]  sample_count;
        logic [TIME_W-1:0]   elapsed_ms;
        logic [SAMPLE_W-1:0] sample0;
        logic [SAMPLE_W-1:0] sample1;
        logic [SAMPLE_W-1:0] sample2;
        logic [SAMPLE_W-1:0] sample3;
        logic [SAMPLE_W-1:0] sample4;
        logic [SAMPLE_W-1:0] sample5;
        logic [SAMPLE_W-1:0] sample6;
        logic [SAMPLE_W-1:0] sample7;
    } in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean_current_ma;
        logic                over_current;
        logic [TIME_W-1:0]   over_time_ms;
    } out_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] threshold_ma;
        logic [TIME_W-1:0]   window_ms;
    } cfg_t;

    // batch summary handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  elapsed;
    } job_t;

    function automatic logic [COUNT_W-1:0] usable_count(logic [COUNT_W-1:0] raw);
        logic [COUNT_W-1:0] n;
        n = raw;
        if (n > COUNT_W'(USABLE_MAX))
        begin
            n = COUNT_W'(USABLE_MAX);
        end
        return n;
    endfunction

endpackage

// ----- rtl/ocpd_front.sv -----
module ocpd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ocpd_pkg::in_t     in_data,
    output logic              push_valid,
    input  logic              push_ready,
    output ocpd_pkg::job_t    push_job
);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_SUM  = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;

    ocpd_pkg::in_t                      item_reg, item_next;
    logic [ocpd_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [ocpd_pkg::COUNT_W-1:0]       idx_reg, idx_next;
    logic [ocpd_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [ocpd_pkg::SAMPLE_W-1:0]      samples [ocpd_pkg::SAMPLE_FIELDS];
    logic [ocpd_pkg::SAMPLE_W-1:0]      cur_sample;

    assign samples[0] = item_reg.sample0;
    assign samples[1] = item_reg.sample1;
    assign samples[2] = item_reg.sample2;
    assign samples[3] = item_reg.sample3;
    assign samples[4] = item_reg.sample4;
    assign samples[5] = item_reg.sample5;
    assign samples[6] = item_reg.sample6;
    assign samples[7] = item_reg.sample7;

    // idx stays below the count while adding, so the low bits suffice
    assign cur_sample = samples[idx_reg[ocpd_pkg::SAMPLE_IDX_W-1:0]];

    assign in_stall = (state_reg != F_IDLE);

    assign push_job.sum     = sum_reg;
    assign push_job.count   = count_reg;
    assign push_job.elapsed = item_reg.elapsed_ms;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        push_valid = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    count_next = ocpd_pkg::usable_count(in_data.sample_count);
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = F_SUM;
                end
            end
            F_SUM:
            begin
                if (idx_reg != count_reg)
                begin
                    // one sample per cycle
                    sum_next = sum_reg + ocpd_pkg::SUM_W'(cur_sample);
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    push_valid = 1'b1;
                    if (push_ready)
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        count_reg <= count_next;
        idx_reg   <= idx_next;
        sum_reg   <= sum_next;
    end

endmodule

// ----- rtl/ocpd_queue.sv -----
module ocpd_queue #(
    parameter int DEPTH = ocpd_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  ocpd_pkg::job_t    push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ocpd_pkg::job_t    pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ocpd_pkg::job_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_job    = entries[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/ocpd_back.sv -----
module ocpd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ocpd_pkg::cfg_t    cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  ocpd_pkg::job_t    pop_job,
    output logic              out_valid,
    input  logic              out_stall,
    output ocpd_pkg::out_t    out_data
);

    localparam int SUM_W  = ocpd_pkg::SUM_W;
    localparam int CNT_W  = ocpd_pkg::COUNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_UPD  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [SUM_W-1:0]              dvd_reg, dvd_next;
    logic [SUM_W-1:0]              quo_reg, quo_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [ocpd_pkg::TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic                          cand_reg, cand_next;
    logic [STEP_W-1:0]             step_reg, step_next;

    logic [ocpd_pkg::SAMPLE_W-1:0] mean_reg, mean_next;
    logic                          above_reg, above_next;
    logic [ocpd_pkg::TIME_W-1:0]   accum_reg, accum_next;
    logic                          status_reg, status_next;

    logic                          out_valid_reg, out_valid_next;
    ocpd_pkg::out_t                out_data_reg, out_data_next;

    logic [ocpd_pkg::PROD_W-1:0]   limit;
    logic [CNT_W:0]                trial;
    logic                          fits;
    logic                          load_ok;
    logic                          above_eff;
    logic [ocpd_pkg::TIME_W:0]     acc_sum;
    logic [ocpd_pkg::TIME_W-1:0]   acc_sat;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pop_ready = (state_reg == B_IDLE);

    // exact form of mean > threshold without a divide
    assign limit = ocpd_pkg::PROD_W'(cfg.threshold_ma) * ocpd_pkg::PROD_W'(pop_job.count);

    // restoring divide, one quotient bit per cycle
    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, count_reg});

    assign load_ok   = !out_valid_reg || !out_stall;
    assign above_eff = (count_reg != '0) ? cand_reg : above_reg;
    assign acc_sum   = {1'b0, accum_reg} + {1'b0, elapsed_reg};
    assign acc_sat   = acc_sum[ocpd_pkg::TIME_W] ? '1 : acc_sum[ocpd_pkg::TIME_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        count_next     = count_reg;
        elapsed_next   = elapsed_reg;
        cand_next      = cand_reg;
        step_next      = step_reg;
        mean_next      = mean_reg;
        above_next     = above_reg;
        accum_next     = accum_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    dvd_next     = pop_job.sum;
                    quo_next     = '0;
                    rem_next     = '0;
                    count_next   = pop_job.count;
                    elapsed_next = pop_job.elapsed;
                    cand_next    = (ocpd_pkg::PROD_W'(pop_job.sum) > limit);
                    step_next    = '0;
                    state_next   = (pop_job.count == '0) ? B_UPD : B_DIV;
                end
            end
            B_DIV:
            begin
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                quo_next = {quo_reg[SUM_W-2:0], fits};
                rem_next = fits ? CNT_W'(trial - {1'b0, count_reg}) : trial[CNT_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = B_UPD;
                end
            end
            B_UPD:
            begin
                if (load_ok)
                begin
                    if (count_reg != '0)
                    begin
                        mean_next = quo_reg[ocpd_pkg::SAMPLE_W-1:0];
                    end
                    above_next = above_eff;
                    if (above_eff)
                    begin
                        accum_next  = acc_sat;
                        status_next = status_reg || (acc_sat >= cfg.window_ms);
                    end
                    else
                    begin
                        accum_next  = '0;
                        status_next = 1'b0;
                    end
                    out_data_next.mean_current_ma = (count_reg != '0)
                                                  ? quo_reg[ocpd_pkg::SAMPLE_W-1:0]
                                                  : mean_reg;
                    out_data_next.over_current    = status_next;
                    out_data_next.over_time_ms    = accum_next;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            mean_reg      <= '0;
            above_reg     <= 1'b0;
            accum_reg     <= '0;
            status_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mean_reg      <= mean_next;
            above_reg     <= above_next;
            accum_reg     <= accum_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        count_reg    <= count_next;
        elapsed_reg  <= elapsed_next;
        cand_reg     <= cand_next;
        step_reg     <= step_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/overcurrent_persistence_detector_top.sv -----
// Overcurrent persistence detector. Each input transfer carries a batch of up to
// eight current samples and the time since the previous batch; each one yields
// exactly one result transfer with the stored mean, the accumulated
// over-threshold time and the overcurrent status. The front end takes one
// batch, adds one sample per cycle and hands a sum to a small queue. The back
// end pops a sum; for a non-empty batch it runs a restoring divider that
// produces one quotient bit per cycle and then updates the state, while an
// empty batch goes straight to the update. The queue lets the front end sum
// the next batch while the back end is still dividing. Threshold and window
// may be written at any time the block has no batch in flight.
module overcurrent_persistence_detector_top #(
    parameter int QUEUE_DEPTH = ocpd_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ocpd_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ocpd_pkg::out_t                     out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ocpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]                        cfg_data
);

    ocpd_pkg::cfg_t cfg_reg, cfg_next;
    logic           q_push_valid, q_push_ready;
    logic           q_pop_valid, q_pop_ready;
    ocpd_pkg::job_t q_push_job, q_pop_job;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ocpd_pkg::REG_THRESHOLD: cfg_next.threshold_ma = cfg_data;
                ocpd_pkg::REG_WINDOW:    cfg_next.window_ms    = cfg_data;
                default:                 cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_ma <= ocpd_pkg::THRESHOLD_RESET;
            cfg_reg.window_ms    <= ocpd_pkg::WINDOW_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ocpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_job   (q_push_job)
    );

    ocpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_job   (q_push_job),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_job    (q_pop_job)
    );

    ocpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_job   (q_pop_job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // front end is busy in the cycle after taking a batch
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("front end took a batch without going busy");

    // back end leaves idle as soon as it pops a sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop_valid && q_pop_ready) |=> !q_pop_ready)
        else $error("back end still idle after a pop");

    // a result only appears after the back end has been busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_pop_ready))
        else $error("result raised without back-end work");

endmodule

// ----- tb/overcurrent_persistence_detector_top_tb.sv -----
`timescale 1ns / 100ps

module overcurrent_persistence_detector_top_tb;

    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 242;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    // indexes with no register behind them, writes must be ignored
    localparam logic [ocpd_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [ocpd_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    class overcurrent_scoreboard;
        logic [ocpd_pkg::SAMPLE_W-1:0] threshold_ma;
        logic [ocpd_pkg::TIME_W-1:0]   window_ms;
        logic [ocpd_pkg::SAMPLE_W-1:0] mean_ma;
        logic [ocpd_pkg::TIME_W-1:0]   accum_ms;
        bit                            above;
        bit                            status;
        ocpd_pkg::out_t                expected_q[$];
        int                            errors;
        int                            batches;
        int                            checked;

        function new();
            threshold_ma = ocpd_pkg::THRESHOLD_RESET;
            window_ms    = ocpd_pkg::WINDOW_RESET;
            mean_ma      = '0;
            accum_ms     = '0;
            above        = 1'b0;
            status       = 1'b0;
            errors       = 0;
            batches      = 0;
            checked      = 0;
        endfunction

        function void write_reg(logic [ocpd_pkg::CFG_INDEX_W-1:0] index, logic [15:0] value);
            case (index)
                ocpd_pkg::REG_THRESHOLD: threshold_ma = value;
                ocpd_pkg::REG_WINDOW:    window_ms = value;
                default:                 ;
            endcase
        endfunction

        function void note_batch(ocpd_pkg::in_t b);
            logic [ocpd_pkg::SAMPLE_W-1:0] samples [ocpd_pkg::SAMPLE_FIELDS];
            int unsigned n;
            int unsigned sum;
            int unsigned total;
            int i;
            ocpd_pkg::out_t r;
            samples = '{b.sample0, b.sample1, b.sample2, b.sample3,
                        b.sample4, b.sample5, b.sample6, b.sample7};
            n = b.sample_count;
            if (n > ocpd_pkg::USABLE_MAX)
            begin
                n = ocpd_pkg::USABLE_MAX;
            end
            // an empty batch keeps the old mean and decision
            if (n > 0)
            begin
                sum = 0;
                for (i = 0; i < n; i++)
                begin
                    sum += samples[i];
                end
                mean_ma = ocpd_pkg::SAMPLE_W'(sum / n);
                above   = sum > threshold_ma * n;
            end
            if (above)
            begin
                total    = accum_ms + b.elapsed_ms;
                accum_ms = (total > 16'hFFFF) ? 16'hFFFF : ocpd_pkg::TIME_W'(total);
                if (accum_ms >= window_ms)
                begin
                    status = 1'b1;
                end
            end
            else
            begin
                accum_ms = '0;
                status   = 1'b0;
            end
            r.mean_current_ma = mean_ma;
            r.over_current    = status;
            r.over_time_ms    = accum_ms;
            expected_q.push_back(r);
            batches++;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(ocpd_pkg::out_t got);
            ocpd_pkg::out_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, mean %0d status %0d time %0d",
                         $time, got.mean_current_ma, got.over_current, got.over_time_ms);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("mean_current_ma", want.mean_current_ma, got.mean_current_ma);
            compare_field("over_current", want.over_current, got.over_current);
            compare_field("over_time_ms", want.over_time_ms, got.over_time_ms);
            checked++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    ocpd_pkg::in_t                    in_data   = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    ocpd_pkg::out_t                   out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ocpd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]                      cfg_data  = '0;

    overcurrent_scoreboard sb = new();

    bit calm          = 1'b0;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int reg_writes    = 0;

    overcurrent_persistence_detector_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ocpd_pkg::SAMPLE_W-1:0] clamp16(int v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > 65535)
        begin
            return '1;
        end
        return ocpd_pkg::SAMPLE_W'(v);
    endfunction

    function automatic ocpd_pkg::in_t uniform_batch(int unsigned count, int unsigned elapsed,
                                                    logic [ocpd_pkg::SAMPLE_W-1:0] value);
        ocpd_pkg::in_t b;
        b.sample_count = ocpd_pkg::COUNT_W'(count);
        b.elapsed_ms   = ocpd_pkg::TIME_W'(elapsed);
        b.sample0      = value;
        b.sample1      = value;
        b.sample2      = value;
        b.sample3      = value;
        b.sample4      = value;
        b.sample5      = value;
        b.sample6      = value;
        b.sample7      = value;
        return b;
    endfunction

    // samples cluster around the threshold, leaning over or under it in runs
    function automatic ocpd_pkg::in_t random_batch(logic [ocpd_pkg::SAMPLE_W-1:0] thr,
                                                   logic [ocpd_pkg::TIME_W-1:0] win,
                                                   bit lean_over);
        ocpd_pkg::in_t b;
        logic [ocpd_pkg::SAMPLE_W-1:0] s [ocpd_pkg::SAMPLE_FIELDS];
        int unsigned pick;
        int offset;
        int i;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            b.sample_count = '0;
        end
        else if (pick < 10)
        begin
            b.sample_count = ocpd_pkg::COUNT_W'($urandom_range(ocpd_pkg::USABLE_MAX + 1, 15));
        end
        else
        begin
            b.sample_count = ocpd_pkg::COUNT_W'($urandom_range(1, ocpd_pkg::USABLE_MAX));
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            b.elapsed_ms = ocpd_pkg::TIME_W'($urandom_range(0, win / 8 + 10));
        end
        else if (pick < 90)
        begin
            b.elapsed_ms = ocpd_pkg::TIME_W'($urandom_range(0, 255));
        end
        else if (pick < 98)
        begin
            b.elapsed_ms = ocpd_pkg::TIME_W'($urandom);
        end
        else
        begin
            b.elapsed_ms = '1;
        end
        for (i = 0; i < ocpd_pkg::SAMPLE_FIELDS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                offset = int'($urandom_range(0, 60));
                if (!lean_over)
                begin
                    offset = -offset;
                end
                s[i] = clamp16(int'(thr) + offset + int'($urandom_range(0, 40)) - 20);
            end
            else if (pick < 85)
            begin
                s[i] = ocpd_pkg::SAMPLE_W'($urandom);
            end
            else if (pick < 95)
            begin
                s[i] = pick[0] ? '1 : '0;
            end
            else
            begin
                s[i] = thr;
            end
        end
        b.sample0 = s[0];
        b.sample1 = s[1];
        b.sample2 = s[2];
        b.sample3 = s[3];
        b.sample4 = s[4];
        b.sample5 = s[5];
        b.sample6 = s[6];
        b.sample7 = s[7];
        return b;
    endfunction

    // valid stays high after the transfer so back-to-back batches need no gap
    task automatic send_batch(ocpd_pkg::in_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [ocpd_pkg::CFG_INDEX_W-1:0] index, logic [15:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sb.write_reg(index, value);
        reg_writes++;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
            begin
                stall_left--;
            end
        end
    end

    // input side first so a same-edge result still finds its expectation
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            sb.note_batch(in_data);
        end
        if (out_valid && !out_stall)
        begin
            sb.check_result(out_data);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("overcurrent_persistence_detector_top_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        ocpd_pkg::in_t                 b;
        logic [ocpd_pkg::SAMPLE_W-1:0] thr;
        logic [ocpd_pkg::TIME_W-1:0]   win;
        bit                            lean_over;
        int                            p;
        int                            k;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: threshold 10000, window 50
        send_batch(uniform_batch(0, 5, 16'hFFFF));
        send_batch(uniform_batch(1, 30, 16'd10001));
        b = uniform_batch(2, 20, 16'hFFFF);
        b.sample0 = 16'd10000;
        b.sample1 = 16'd10001;
        send_batch(b);
        // status must hold while the window is raised past the accumulator
        write_reg(ocpd_pkg::REG_WINDOW, 16'd1000);
        send_batch(uniform_batch(0, 1, 16'h0000));
        send_batch(uniform_batch(8, 16'hFFFF, 16'hFFFF));
        send_batch(uniform_batch(15, 16'hFFFF, 16'hFFFF));
        send_batch(uniform_batch(9, 3, 16'd40000));
        send_batch(uniform_batch(0, 7, 16'h0000));
        send_batch(uniform_batch(3, 10, 16'd10000));
        write_reg(ocpd_pkg::REG_THRESHOLD, 16'd0);
        write_reg(ocpd_pkg::REG_WINDOW, 16'd0);
        send_batch(uniform_batch(1, 0, 16'd0));
        send_batch(uniform_batch(1, 0, 16'd1));
        send_batch(uniform_batch(1, 9, 16'd1));
        // empty batch keeps a decision formed under the old threshold
        write_reg(ocpd_pkg::REG_THRESHOLD, 16'hFFFF);
        send_batch(uniform_batch(0, 4, 16'h0000));
        send_batch(uniform_batch(8, 2, 16'hFFFF));
        b = uniform_batch(8, 16'hAAAA, 16'hAAAA);
        b.sample1 = 16'h5555;
        b.sample3 = 16'h5555;
        b.sample5 = 16'h5555;
        b.sample7 = 16'h5555;
        send_batch(b);
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h0000);
        send_batch(uniform_batch(12, 16'h5555, 16'h0001));

        lean_over = 1'b1;
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    thr = 16'd10000;
                    win = 16'd50;
                end
                1:
                begin
                    thr = 16'd0;
                    win = 16'd0;
                end
                2:
                begin
                    thr = 16'hFFFF;
                    win = 16'hFFFF;
                end
                3:
                begin
                    thr = 16'd0;
                    win = 16'hFFFF;
                end
                4:
                begin
                    thr = 16'hFFFF;
                    win = 16'd0;
                end
                5:
                begin
                    thr = 16'd1000;
                    win = 16'd100;
                end
                default:
                begin
                    thr = ocpd_pkg::SAMPLE_W'($urandom);
                    win = ocpd_pkg::TIME_W'($urandom_range(0, 2000));
                end
            endcase
            write_reg(ocpd_pkg::REG_THRESHOLD, thr);
            write_reg(ocpd_pkg::REG_WINDOW, win);
            write_reg(p[0] ? REG_SPARE_3 : REG_SPARE_2, 16'($urandom));
            calm = (p == 5);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                begin
                    wait_idle();
                end
                if ($urandom_range(0, 11) == 0)
                begin
                    lean_over = !lean_over;
                end
                send_batch(random_batch(thr, win, lean_over));
            end
        end
        calm = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.errors += sb.pending();
        $display("covered %0d batches and %0d register writes over %0d settings",
                 sb.batches, reg_writes, PHASES + 3);
        $display("%0d results checked, %0d errors", sb.checked, sb.errors);
        if (sb.errors == 0)
        begin
            $display("overcurrent_persistence_detector_top_tb: PASS");
        end
        else
        begin
            $display("overcurrent_persistence_detector_top_tb: FAIL");
        end
        $finish;
    end

endmodule
